[src/assert_macros.svh]
// Assertion helpers; the using module must have i_clk and i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define ILT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define ILT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[src/ilt_pkg.sv]
package ilt_pkg;

    // ASCII codes used by the parser
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_ONE  = 8'h31;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_UC_A = 8'h41;
    localparam logic [7:0] CH_UC_F = 8'h46;
    localparam logic [7:0] CH_LC_A = 8'h61;
    localparam logic [7:0] CH_LC_F = 8'h66;
    localparam logic [7:0] CH_LC_X = 8'h78;
    localparam logic [7:0] CH_UC_X = 8'h58;
    localparam logic [7:0] CH_LC_U = 8'h75;
    localparam logic [7:0] CH_UC_U = 8'h55;
    localparam logic [7:0] CH_LC_L = 8'h6c;
    localparam logic [7:0] CH_UC_L = 8'h4c;

    localparam logic [4:0] NO_DIGIT = 5'd16;

    // type codes
    localparam logic [2:0] TY_INT    = 3'd0;
    localparam logic [2:0] TY_UINT   = 3'd1;
    localparam logic [2:0] TY_LONG   = 3'd2;
    localparam logic [2:0] TY_ULONG  = 3'd3;
    localparam logic [2:0] TY_LLONG  = 3'd4;
    localparam logic [2:0] TY_ULLONG = 3'd5;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_BAD   = 2'd2;

    typedef enum logic [1:0] {
        SK_NONE = 2'd0,
        SK_U    = 2'd1,
        SK_L    = 2'd2
    } t_sfx;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } t_in_item;

    typedef struct packed {
        logic [63:0] value;
        logic [2:0]  type_code;
        logic [1:0]  status;
    } t_out_item;

    // Final parse state of one literal, handed to the type selector.
    typedef struct packed {
        logic [63:0] acc;
        logic        ovf;
        logic        bad;
        logic        dec;
        t_sfx        sfx;
    } t_snap;

    function automatic logic [4:0] digit_of(input logic [7:0] c);
        logic [4:0] d;
        d = NO_DIGIT;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d = 5'(c - CH_ZERO);
        end else if (c >= CH_LC_A && c <= CH_LC_F) begin
            d = 5'(c - CH_LC_A) + 5'd10;
        end else if (c >= CH_UC_A && c <= CH_UC_F) begin
            d = 5'(c - CH_UC_A) + 5'd10;
        end
        return d;
    endfunction

    function automatic t_sfx suffix_of(input logic [7:0] c);
        t_sfx s;
        s = SK_NONE;
        if (c == CH_LC_U || c == CH_UC_U) begin
            s = SK_U;
        end else if (c == CH_LC_L || c == CH_UC_L) begin
            s = SK_L;
        end
        return s;
    endfunction

endpackage

[src/ilt_step.sv]
`include "assert_macros.svh"

module ilt_step (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_fire,
    input  ilt_pkg::t_in_item i_item,
    output ilt_pkg::t_snap  o_snap
);
    import ilt_pkg::*;

    typedef enum logic [4:0] {
        PH_START  = 5'b00001,
        PH_ZERO   = 5'b00010,
        PH_HEXPFX = 5'b00100,
        PH_DIGITS = 5'b01000,
        PH_SUFFIX = 5'b10000
    } t_phase;

    typedef enum logic [1:0] {
        RX_DEC = 2'd0,
        RX_OCT = 2'd1,
        RX_HEX = 2'd2
    } t_radix;

    t_phase      r_phase, n_phase;
    t_radix      r_radix, n_radix;
    logic [63:0] r_acc, n_acc;
    logic        r_ovf, n_ovf;
    t_sfx        r_sfx, n_sfx;
    logic        r_bad, n_bad;

    logic [7:0]  c;
    logic [4:0]  d;
    t_sfx        sk;
    logic        d_in_base;
    logic [67:0] prod;
    logic [67:0] sum;

    assign c  = i_item.char_code;
    assign d  = digit_of(c);
    assign sk = suffix_of(c);

    // acc * base + d, 68 bits wide so the carry-out flags overflow
    always_comb begin
        case (r_radix)
            RX_OCT: begin
                prod      = {4'd0, r_acc} << 3;
                d_in_base = d < 5'd8;
            end
            RX_HEX: begin
                prod      = {4'd0, r_acc} << 4;
                d_in_base = d < 5'd16;
            end
            default: begin
                prod      = ({4'd0, r_acc} << 3) + ({4'd0, r_acc} << 1);
                d_in_base = d < 5'd10;
            end
        endcase
        sum = prod + {63'd0, d};
    end

    always_comb begin
        n_phase = r_phase;
        n_radix = r_radix;
        n_acc   = r_acc;
        n_ovf   = r_ovf;
        n_sfx   = r_sfx;
        n_bad   = r_bad;
        if (!r_bad) begin
            case (r_phase)
                PH_START: begin
                    if (c == CH_ZERO) begin
                        n_phase = PH_ZERO;
                        n_radix = RX_OCT;
                        n_acc   = 64'd0;
                    end else if (c >= CH_ONE && c <= CH_NINE) begin
                        n_phase = PH_DIGITS;
                        n_radix = RX_DEC;
                        n_acc   = {59'd0, d};
                    end else begin
                        n_bad = 1'b1;
                    end
                end
                PH_ZERO: begin
                    if (c == CH_LC_X || c == CH_UC_X) begin
                        n_phase = PH_HEXPFX;
                        n_radix = RX_HEX;
                    end else if (d < 5'd8) begin
                        n_phase = PH_DIGITS;
                        n_acc   = {59'd0, d};
                    end else if (sk != SK_NONE) begin
                        n_phase = PH_SUFFIX;
                        n_sfx   = sk;
                    end else begin
                        n_bad = 1'b1;
                    end
                end
                PH_HEXPFX: begin
                    if (d < 5'd16) begin
                        n_phase = PH_DIGITS;
                        n_acc   = {59'd0, d};
                    end else begin
                        n_bad = 1'b1;
                    end
                end
                PH_DIGITS: begin
                    if (d_in_base) begin
                        n_acc = sum[63:0];
                        if (sum[67:64] != 4'd0) begin
                            n_ovf = 1'b1;
                        end
                    end else if (sk != SK_NONE) begin
                        n_phase = PH_SUFFIX;
                        n_sfx   = sk;
                    end else begin
                        n_bad = 1'b1;
                    end
                end
                PH_SUFFIX: begin
                    // later u/l letters are ignored
                    if (sk == SK_NONE) begin
                        n_bad = 1'b1;
                    end
                end
                default: begin
                    n_bad = 1'b1;
                end
            endcase
        end
    end

    always_comb begin
        o_snap.acc = n_acc;
        o_snap.ovf = n_ovf;
        o_snap.bad = n_bad || n_phase == PH_START || n_phase == PH_HEXPFX;
        o_snap.dec = n_radix == RX_DEC;
        o_snap.sfx = n_sfx;
    end

    // state returns to start after the last character of a literal
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_radix <= RX_DEC;
            r_acc   <= 64'd0;
            r_ovf   <= 1'b0;
            r_sfx   <= SK_NONE;
            r_bad   <= 1'b0;
        end else if (i_fire) begin
            if (i_item.last_char) begin
                r_phase <= PH_START;
                r_radix <= RX_DEC;
                r_acc   <= 64'd0;
                r_ovf   <= 1'b0;
                r_sfx   <= SK_NONE;
                r_bad   <= 1'b0;
            end else begin
                r_phase <= n_phase;
                r_radix <= n_radix;
                r_acc   <= n_acc;
                r_ovf   <= n_ovf;
                r_sfx   <= n_sfx;
                r_bad   <= n_bad;
            end
        end
    end

    `ILT_ASSERT(a_clear_after_last, i_fire && i_item.last_char |=> r_phase == PH_START && r_acc == 64'd0 && !r_ovf && !r_bad, "parse state not cleared after last item")
    `ILT_ASSERT(a_ovf_in_digits, $rose(r_ovf) |-> r_phase == PH_DIGITS, "overflow set outside digit phase")
    `ILT_ASSERT(a_hexpfx_radix, r_phase == PH_HEXPFX |-> r_radix == RX_HEX, "hex prefix without hex radix")

endmodule

[src/ilt_classify.sv]
module ilt_classify #(
    parameter int INT_BITS = 32
) (
    input  ilt_pkg::t_snap     i_snap,
    output ilt_pkg::t_out_item o_item
);
    import ilt_pkg::*;

    localparam logic [63:0] ALL_ONES = {64{1'b1}};
    localparam logic [63:0] INT_MAX  = ALL_ONES >> (65 - INT_BITS);
    localparam logic [63:0] UINT_MAX = ALL_ONES >> (64 - INT_BITS);
    localparam logic [63:0] LONG_MAX = ALL_ONES >> 1;

    logic       fits_int, fits_uint, fits_long;
    logic [2:0] ty;
    logic [1:0] st;

    assign fits_int  = i_snap.acc <= INT_MAX;
    assign fits_uint = i_snap.acc <= UINT_MAX;
    assign fits_long = i_snap.acc <= LONG_MAX;

    always_comb begin
        ty = TY_INT;
        st = ST_OK;
        if (i_snap.bad) begin
            st = ST_BAD;
        end else if (i_snap.ovf) begin
            st = ST_RANGE;
        end else begin
            case (i_snap.sfx)
                SK_NONE: begin
                    if (fits_int) begin
                        ty = TY_INT;
                    end else if (!i_snap.dec && fits_uint) begin
                        ty = TY_UINT;
                    end else if (fits_long) begin
                        ty = TY_LONG;
                    end else if (!i_snap.dec) begin
                        ty = TY_ULONG;
                    end else begin
                        st = ST_RANGE;
                    end
                end
                SK_U: begin
                    ty = fits_uint ? TY_UINT : TY_ULONG;
                end
                default: begin
                    if (fits_long) begin
                        ty = TY_LONG;
                    end else if (!i_snap.dec) begin
                        ty = TY_ULONG;
                    end else begin
                        st = ST_RANGE;
                    end
                end
            endcase
        end
    end

    // error results carry zero value and type
    always_comb begin
        o_item.status    = st;
        o_item.type_code = (st == ST_OK) ? ty : TY_INT;
        o_item.value     = (st == ST_OK) ? i_snap.acc : 64'd0;
    end

endmodule

[src/c_integer_literal_typer_top.sv]
// channel  direction  payload                          handshake
// in       input      t_in_item  {char_code, last_char} i_in_valid / o_in_stall
// out      output     t_out_item {value, type_code, status} o_out_valid / i_out_stall
//
// One character per cycle unless a last character meets a stalled parse-step stage.
// Stages: input register, parse step, type select; a result is registered in each in turn.
// The 68-bit shift-add of the accumulator sets the step path; type select is one compare deep.
// Synchronous reset empties all stages and returns the parser to start of literal.
// Output stall holds the result; stalls back up only as far as a full stage.
`include "assert_macros.svh"

module c_integer_literal_typer_top #(
    parameter int INT_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  ilt_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ilt_pkg::t_out_item o_out_item
);
    import ilt_pkg::*;

    logic      r_a_valid;
    t_in_item  r_a_item;
    logic      r_b_valid;
    t_snap     r_b_snap;
    logic      r_out_valid;
    t_out_item r_out_item;

    logic      out_free, b_free, a_go, a_free;
    t_snap     step_snap;
    t_out_item cls_item;

    assign out_free = !r_out_valid || !i_out_stall;
    assign b_free   = !r_b_valid || out_free;
    // a non-final character only updates parse state, so it never waits
    assign a_go     = r_a_valid && (!r_a_item.last_char || b_free);
    assign a_free   = !r_a_valid || a_go;

    assign o_in_stall  = !a_free;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    ilt_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (a_go),
        .i_item  (r_a_item),
        .o_snap  (step_snap)
    );

    ilt_classify #(
        .INT_BITS (INT_BITS)
    ) u_classify (
        .i_snap (r_b_snap),
        .o_item (cls_item)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (a_free) begin
                r_a_valid <= i_in_valid;
            end
            if (b_free) begin
                r_b_valid <= a_go && r_a_item.last_char;
            end
            if (out_free) begin
                r_out_valid <= r_b_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_free && i_in_valid) begin
            r_a_item <= i_in_item;
        end
        if (a_go && r_a_item.last_char) begin
            r_b_snap <= step_snap;
        end
        if (out_free && r_b_valid) begin
            r_out_item <= cls_item;
        end
    end

    `ILT_ASSERT(a_err_zeroed, o_out_valid && o_out_item.status != ST_OK |-> o_out_item.value == 64'd0 && o_out_item.type_code == TY_INT, "error item with nonzero value or type")
    `ILT_ASSERT(a_int_fits, o_out_valid && o_out_item.status == ST_OK && o_out_item.type_code == TY_INT |-> o_out_item.value[63:INT_BITS-1] == '0, "int item exceeds int range")
    `ILT_ASSERT_ALWAYS(a_reset_empties, !i_rst_n |=> !o_out_valid && !r_b_valid && !r_a_valid, "pipeline not empty after reset")

endmodule

[tb/tb_c_integer_literal_typer_top.sv]
module tb_c_integer_literal_typer_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ilt_pkg::*;

    localparam int INT_BITS = 32;
    localparam logic [63:0] UINT_MAX_V = {64{1'b1}} >> (64 - INT_BITS);
    localparam logic [63:0] INT_MAX_V  = UINT_MAX_V >> 1;
    localparam logic [63:0] LONG_MAX_V = {1'b0, {63{1'b1}}};
    localparam int TOTAL_CHARS = 600;
    localparam int MAX_PRINTED = 40;

    typedef enum logic [2:0] {
        LP_START,
        LP_ZERO,
        LP_HEX_PREFIX,
        LP_DIGITS,
        LP_SUFFIX
    } t_lit_phase;

    typedef enum logic [1:0] {
        RDX_DEC,
        RDX_OCT,
        RDX_HEX
    } t_lit_radix;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_item = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_item;

    c_integer_literal_typer_top #(
        .INT_BITS(INT_BITS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_item (o_out_item)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // parser state mirrored by the predictor
    t_lit_phase lit_phase = LP_START;
    t_lit_radix lit_radix = RDX_DEC;
    logic [63:0] lit_acc = '0;
    logic        lit_ovf = 1'b0;
    t_sfx        lit_sfx = SK_NONE;
    logic        lit_bad = 1'b0;

    t_out_item expected_literals[$];
    int mismatch_count = 0;
    int parsed_chars = 0;
    int burst_left = 0;

    logic [7:0] sink_cycle = '0;
    logic [1:0] sink_mode = '0;

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED) begin
            $display("%0t ns: %s", $time, msg);
        end
    endtask

    task automatic parse_literal_char(input logic [7:0] c, input logic last);
        logic [4:0]  d;
        logic [4:0]  base;
        t_sfx        sk;
        logic [67:0] wide;
        logic        decimal;
        t_out_item   res;
        d = NO_DIGIT;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d = 5'(c - CH_ZERO);
        end else if (c >= CH_LC_A && c <= CH_LC_F) begin
            d = 5'(c - CH_LC_A) + 5'd10;
        end else if (c >= CH_UC_A && c <= CH_UC_F) begin
            d = 5'(c - CH_UC_A) + 5'd10;
        end
        sk = SK_NONE;
        if (c == CH_LC_U || c == CH_UC_U) begin
            sk = SK_U;
        end else if (c == CH_LC_L || c == CH_UC_L) begin
            sk = SK_L;
        end
        base = (lit_radix == RDX_HEX) ? 5'd16 : (lit_radix == RDX_OCT) ? 5'd8 : 5'd10;
        parsed_chars++;
        if (!lit_bad) begin
            case (lit_phase)
                LP_START: begin
                    if (c == CH_ZERO) begin
                        lit_phase = LP_ZERO;
                        lit_radix = RDX_OCT;
                        lit_acc = '0;
                    end else if (c >= CH_ONE && c <= CH_NINE) begin
                        lit_phase = LP_DIGITS;
                        lit_radix = RDX_DEC;
                        lit_acc = 64'(d);
                    end else begin
                        lit_bad = 1'b1;
                    end
                end
                LP_ZERO: begin
                    if (c == CH_LC_X || c == CH_UC_X) begin
                        lit_phase = LP_HEX_PREFIX;
                        lit_radix = RDX_HEX;
                    end else if (d < 5'd8) begin
                        lit_phase = LP_DIGITS;
                        lit_acc = 64'(d);
                    end else if (sk != SK_NONE) begin
                        lit_phase = LP_SUFFIX;
                        lit_sfx = sk;
                    end else begin
                        lit_bad = 1'b1;
                    end
                end
                LP_HEX_PREFIX: begin
                    if (d < 5'd16) begin
                        lit_phase = LP_DIGITS;
                        lit_acc = 64'(d);
                    end else begin
                        lit_bad = 1'b1;
                    end
                end
                LP_DIGITS: begin
                    if (d < base) begin
                        wide = {4'b0, lit_acc} * base + d;
                        if (wide[67:64] != 4'd0) begin
                            lit_ovf = 1'b1;
                        end
                        lit_acc = wide[63:0];
                    end else if (sk != SK_NONE) begin
                        lit_phase = LP_SUFFIX;
                        lit_sfx = sk;
                    end else begin
                        lit_bad = 1'b1;
                    end
                end
                default: begin
                    // later suffix letters are accepted and ignored
                    if (sk == SK_NONE) begin
                        lit_bad = 1'b1;
                    end
                end
            endcase
        end
        if (last) begin
            res = '0;
            decimal = (lit_radix == RDX_DEC);
            if (lit_bad || lit_phase == LP_START || lit_phase == LP_HEX_PREFIX) begin
                res.status = ST_BAD;
            end else if (lit_ovf) begin
                res.status = ST_RANGE;
            end else begin
                res.status = ST_OK;
                case (lit_sfx)
                    SK_NONE: begin
                        if (lit_acc <= INT_MAX_V) begin
                            res.type_code = TY_INT;
                        end else if (!decimal && lit_acc <= UINT_MAX_V) begin
                            res.type_code = TY_UINT;
                        end else if (lit_acc <= LONG_MAX_V) begin
                            res.type_code = TY_LONG;
                        end else if (!decimal) begin
                            res.type_code = TY_ULONG;
                        end else begin
                            res.status = ST_RANGE;
                        end
                    end
                    SK_U: begin
                        res.type_code = (lit_acc <= UINT_MAX_V) ? TY_UINT : TY_ULONG;
                    end
                    default: begin
                        if (lit_acc <= LONG_MAX_V) begin
                            res.type_code = TY_LONG;
                        end else if (!decimal) begin
                            res.type_code = TY_ULONG;
                        end else begin
                            res.status = ST_RANGE;
                        end
                    end
                endcase
                if (res.status == ST_OK) begin
                    res.value = lit_acc;
                end
            end
            expected_literals.push_back(res);
            lit_phase = LP_START;
            lit_radix = RDX_DEC;
            lit_acc = '0;
            lit_ovf = 1'b0;
            lit_sfx = SK_NONE;
            lit_bad = 1'b0;
        end
    endtask

    // Called right after a rising edge; returns right after the edge that took the item.
    task automatic send_item(input logic [7:0] c, input logic last);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        i_in_valid <= 1'b1;
        i_in_item <= '{char_code: c, last_char: last};
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) begin
            @(posedge i_clk);
        end
        burst_left--;
        parse_literal_char(c, last);
    endtask

    task automatic send_bytes(input logic [7:0] lit[$]);
        for (int i = 0; i < lit.size(); i++) begin
            send_item(lit[i], i == lit.size() - 1);
        end
    endtask

    task automatic send_literal(input string s);
        logic [7:0] lit[$];
        for (int i = 0; i < s.len(); i++) begin
            lit.push_back(s[i]);
        end
        send_bytes(lit);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (expected_literals.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    function automatic logic [7:0] suffix_letter();
        case ($urandom_range(0, 3))
            0: return CH_LC_U;
            1: return CH_UC_U;
            2: return CH_LC_L;
            default: return CH_UC_L;
        endcase
    endfunction

    task automatic send_random_literal();
        logic [7:0]  lit[$];
        logic [63:0] v;
        logic [4:0]  base;
        logic [3:0]  dig;
        int          kind;
        int          n;
        kind = $urandom_range(0, 9);
        if (kind == 9) begin
            // noise: arbitrary bytes
            n = $urandom_range(1, 5);
            repeat (n) lit.push_back(8'($urandom_range(0, 255)));
        end else begin
            case ($urandom_range(0, 3))
                0: v = 64'($urandom_range(0, 999));
                1: v = {$urandom, $urandom} >> $urandom_range(0, 63);
                default: begin
                    case ($urandom_range(0, 3))
                        0: v = INT_MAX_V;
                        1: v = UINT_MAX_V;
                        2: v = LONG_MAX_V;
                        default: v = '1;
                    endcase
                    v = v + 64'($urandom_range(0, 2)) - 64'd1;
                end
            endcase
            case ($urandom_range(0, 2))
                0: base = 5'd10;
                1: base = 5'd8;
                default: base = 5'd16;
            endcase
            if (v == 0) begin
                lit.push_back(CH_ZERO);
            end
            while (v != 0) begin
                dig = 4'(v % base);
                if (dig < 4'd10) begin
                    lit.push_front(CH_ZERO + 8'(dig));
                end else if ($urandom_range(0, 1) == 1) begin
                    lit.push_front(CH_UC_A + 8'(dig - 4'd10));
                end else begin
                    lit.push_front(CH_LC_A + 8'(dig - 4'd10));
                end
                v = v / base;
            end
            // extra digits push big values past 64 bits
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 3)) lit.push_back(lit[0]);
            end
            if (base == 5'd8) begin
                lit.push_front(CH_ZERO);
            end else if (base == 5'd16) begin
                lit.push_front(($urandom_range(0, 1) == 1) ? CH_UC_X : CH_LC_X);
                lit.push_front(CH_ZERO);
            end
            if ($urandom_range(0, 2) != 0) begin
                lit.push_back(suffix_letter());
                if ($urandom_range(0, 2) == 0) begin
                    repeat ($urandom_range(1, 2)) lit.push_back(suffix_letter());
                end
            end
            if (kind == 8) begin
                // broken: one byte replaced, or cut short
                if ($urandom_range(0, 1) == 1) begin
                    lit[$urandom_range(0, lit.size() - 1)] = 8'($urandom_range(0, 255));
                end else begin
                    n = $urandom_range(1, lit.size());
                    while (lit.size() > n) void'(lit.pop_back());
                end
            end
        end
        send_bytes(lit);
    endtask

    task automatic test_basic_forms();
        send_literal("0");
        send_literal("7");
        send_literal("0X2aU");
        send_literal("017Ll");
    endtask

    task automatic test_malformed();
        send_literal("0x");
        send_literal("09");
        send_literal("3lq");
        send_item(8'hFF, 1'b1);
        send_item(CH_ONE, 1'b0);
        send_item(8'h00, 1'b1);
    endtask

    task automatic test_range_limits();
        send_literal("2147483648");
        send_literal("0x8000000000000000");
        send_literal("99999999999999999999");
    endtask

    task automatic test_drain_pause();
        repeat (4) send_random_literal();
        wait_drained();
        repeat (4) send_random_literal();
    endtask

    // fills up the run to about TOTAL_CHARS items
    task automatic test_random_literals();
        while (parsed_chars < TOTAL_CHARS) begin
            send_random_literal();
        end
    endtask

    // receiver back-pressure, mode changes whenever sink_cycle[5:0] is zero
    always @(posedge i_clk) begin
        sink_cycle <= sink_cycle + 8'd1;
        if (sink_cycle[5:0] == 6'd0) begin
            sink_mode <= 2'($urandom_range(0, 3));
        end
        case (sink_mode)
            2'd0: i_out_stall <= 1'b0;
            2'd1: i_out_stall <= ($urandom_range(0, 3) == 0);
            2'd2: i_out_stall <= (sink_cycle[2:0] < 3'd3);
            default: i_out_stall <= ($urandom_range(0, 1) == 0);
        endcase
    end

    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
            if (expected_literals.size() == 0) begin
                report_mismatch($sformatf("unexpected result value %h type %0d status %0d",
                    o_out_item.value, o_out_item.type_code, o_out_item.status));
            end else begin
                want = expected_literals.pop_front();
                if (o_out_item.value !== want.value) begin
                    report_mismatch($sformatf("value %h, want %h",
                        o_out_item.value, want.value));
                end
                if (o_out_item.type_code !== want.type_code) begin
                    report_mismatch($sformatf("type_code %0d, want %0d",
                        o_out_item.type_code, want.type_code));
                end
                if (o_out_item.status !== want.status) begin
                    report_mismatch($sformatf("status %0d, want %0d",
                        o_out_item.status, want.status));
                end
            end
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_basic_forms();
        test_malformed();
        test_range_limits();
        test_drain_pause();
        test_random_literals();
        wait_drained();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
